FILE: design/xenc_pkg.sv
package xenc_pkg;

    localparam int unsigned MAX_BYTES = 19;
    localparam int unsigned CNT_W     = 5;

    typedef enum logic [5:0] {
        OP_MOV_IMM   = 6'd0,  OP_MOV      = 6'd1,  OP_ADD      = 6'd2,  OP_SUB      = 6'd3,
        OP_CMP       = 6'd4,  OP_TEST     = 6'd5,  OP_IMUL     = 6'd6,  OP_IDIV     = 6'd7,
        OP_NEG       = 6'd8,  OP_AND      = 6'd9,  OP_OR       = 6'd10, OP_XOR      = 6'd11,
        OP_NOT       = 6'd12, OP_SHL      = 6'd13, OP_SHR      = 6'd14, OP_AND_IMM  = 6'd15,
        OP_POPCNT    = 6'd16, OP_LOAD64   = 6'd17, OP_STORE64  = 6'd18, OP_LOAD32   = 6'd19,
        OP_STORE32   = 6'd20, OP_MOVZX8   = 6'd21, OP_STORE8   = 6'd22, OP_PUSH     = 6'd23,
        OP_POP       = 6'd24, OP_LOAD_FR  = 6'd25, OP_STORE_FR = 6'd26, OP_LOAD_ABS = 6'd27,
        OP_STORE_ABS = 6'd28, OP_JMP      = 6'd29, OP_CALL     = 6'd30, OP_RET      = 6'd31,
        OP_JCC       = 6'd32, OP_PATCH    = 6'd33, OP_JMP_TO   = 6'd34, OP_SETCC    = 6'd35,
        OP_PROLOGUE  = 6'd36, OP_EPILOGUE = 6'd37, OP_ADD_I8   = 6'd38, OP_SUB_I8   = 6'd39,
        OP_PUSH_R    = 6'd40, OP_POP_R    = 6'd41, OP_MOV_RR   = 6'd42, OP_ADD_RR   = 6'd43,
        OP_SUB_RR    = 6'd44, OP_SYSCALL  = 6'd45, OP_EMIT_SC  = 6'd46, OP_BAD     = 6'd63
    } op_t;

    // one classified request: the byte string and how offsets are formed
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      patch;
        logic [31:0]               target;
        logic [31:0]               rel_base;
        logic                      rel_mode;
    } enc_t;

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                         input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

endpackage

FILE: design/xenc_front.sv
module xenc_front
    import xenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [5:0]  operation,
    input  logic [3:0]  reg_a,
    input  logic [3:0]  reg_b,
    input  logic [63:0] immediate,
    input  logic [31:0] displacement,
    input  logic [3:0]  cond_code,
    input  logic [31:0] target,
    input  logic [2:0]  arg_count,
    output logic        enc_valid,
    input  logic        enc_ready,
    output enc_t        enc
);

    enc_t             enc_reg;
    enc_t             enc_next;
    logic             enc_valid_reg;
    logic [MAX_BYTES-1:0][7:0] bb;
    logic [CNT_W-1:0] n;
    logic [2:0]       a;
    logic [2:0]       b;
    logic [2:0]       nargs;
    logic [7:0]       rex;
    logic             acc;

    // add one byte to the string
    function automatic void put(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                                inout logic [CNT_W-1:0] cnt, input logic [7:0] v);
        buf_v[cnt] = v;
        cnt = cnt + 1'b1;
    endfunction

    function automatic void put32(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                                  inout logic [CNT_W-1:0] cnt, input logic [31:0] v);
        put(buf_v, cnt, v[7:0]);
        put(buf_v, cnt, v[15:8]);
        put(buf_v, cnt, v[23:16]);
        put(buf_v, cnt, v[31:24]);
    endfunction

    function automatic void op_imm(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                                   inout logic [CNT_W-1:0] cnt, input logic [2:0] r,
                                   input logic [63:0] v);
        if (v <= 64'h7FFF_FFFF) begin
            put(buf_v, cnt, 8'hB8 + {5'd0, r});
            put32(buf_v, cnt, v[31:0]);
        end
        else if (v >= 64'hFFFF_FFFF_8000_0000) begin
            put(buf_v, cnt, 8'h48);
            put(buf_v, cnt, 8'hC7);
            put(buf_v, cnt, modrm(2'd3, 3'd0, r));
            put32(buf_v, cnt, v[31:0]);
        end
        else begin
            put(buf_v, cnt, 8'h48);
            put(buf_v, cnt, 8'hB8 + {5'd0, r});
            put32(buf_v, cnt, v[31:0]);
            put32(buf_v, cnt, v[63:32]);
        end
    endfunction

    function automatic void rr(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                               inout logic [CNT_W-1:0] cnt, input logic [7:0] op,
                               input logic [2:0] rg, input logic [2:0] rm);
        put(buf_v, cnt, 8'h48);
        put(buf_v, cnt, op);
        put(buf_v, cnt, modrm(2'd3, rg, rm));
    endfunction

    function automatic void mem_base(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                                     inout logic [CNT_W-1:0] cnt, input logic [2:0] rg,
                                     input logic [2:0] base, input logic [31:0] d);
        put(buf_v, cnt, modrm(2'd2, rg, base));
        if (base == 3'd4)
            put(buf_v, cnt, 8'h24);
        put32(buf_v, cnt, d);
    endfunction

    function automatic void popx(inout logic [MAX_BYTES-1:0][7:0] buf_v,
                                 inout logic [CNT_W-1:0] cnt, input logic [7:0] base_op,
                                 input logic [3:0] r);
        if (r[3])
            put(buf_v, cnt, 8'h41);
        put(buf_v, cnt, base_op + {5'd0, r[2:0]});
    endfunction

    assign a     = reg_a[2:0];
    assign b     = reg_b[2:0];
    assign nargs = (arg_count > 3'd6) ? 3'd6 : arg_count;
    assign rex   = 8'h48 | {5'd0, reg_b[3], 1'b0, reg_a[3]};
    assign acc   = valid && ready;
    assign ready = !enc_valid_reg || enc_ready;

    // classify the request into its byte string
    always_comb
    begin
        bb       = '0;
        n        = '0;
        enc_next = '0;
        unique case (op_t'(operation)) inside
            OP_MOV_IMM:   op_imm(bb, n, a, immediate);
            OP_MOV:       rr(bb, n, 8'h89, b, a);
            OP_ADD:       rr(bb, n, 8'h01, b, a);
            OP_SUB:       rr(bb, n, 8'h29, b, a);
            OP_CMP:       rr(bb, n, 8'h39, b, a);
            OP_TEST:      rr(bb, n, 8'h85, b, a);
            OP_IMUL:
            begin
                put(bb, n, 8'h48); put(bb, n, 8'h0F); put(bb, n, 8'hAF);
                put(bb, n, modrm(2'd3, a, b));
            end
            OP_IDIV:
            begin
                put(bb, n, 8'h48); put(bb, n, 8'h99); rr(bb, n, 8'hF7, 3'd7, a);
            end
            OP_NEG:       rr(bb, n, 8'hF7, 3'd3, a);
            OP_AND:       rr(bb, n, 8'h21, b, a);
            OP_OR:        rr(bb, n, 8'h09, b, a);
            OP_XOR:       rr(bb, n, 8'h31, b, a);
            OP_NOT:       rr(bb, n, 8'hF7, 3'd2, a);
            OP_SHL:       rr(bb, n, 8'hD3, 3'd4, a);
            OP_SHR:       rr(bb, n, 8'hD3, 3'd5, a);
            OP_AND_IMM:
            begin
                rr(bb, n, 8'h81, 3'd4, a); put32(bb, n, immediate[31:0]);
            end
            OP_POPCNT:
            begin
                put(bb, n, 8'hF3); put(bb, n, 8'h48); put(bb, n, 8'h0F);
                put(bb, n, 8'hB8); put(bb, n, modrm(2'd3, a, b));
            end
            OP_LOAD64:
            begin
                put(bb, n, 8'h48); put(bb, n, 8'h8B); mem_base(bb, n, a, b, displacement);
            end
            OP_STORE64:
            begin
                put(bb, n, 8'h48); put(bb, n, 8'h89); mem_base(bb, n, a, b, displacement);
            end
            OP_LOAD32:
            begin
                put(bb, n, 8'h8B); mem_base(bb, n, a, b, displacement);
            end
            OP_STORE32:
            begin
                put(bb, n, 8'h89); mem_base(bb, n, a, b, displacement);
            end
            OP_MOVZX8:
            begin
                put(bb, n, 8'h48); put(bb, n, 8'h0F); put(bb, n, 8'hB6);
                mem_base(bb, n, a, b, displacement);
            end
            OP_STORE8:
            begin
                if (a[2])
                    put(bb, n, 8'h40);
                put(bb, n, 8'h88); mem_base(bb, n, a, b, displacement);
            end
            OP_PUSH:      put(bb, n, 8'h50 + {5'd0, a});
            OP_POP:       put(bb, n, 8'h58 + {5'd0, a});
            OP_LOAD_FR, OP_STORE_FR:
            begin
                put(bb, n, 8'h48);
                put(bb, n, (operation == OP_LOAD_FR) ? 8'h8B : 8'h89);
                if ($signed(displacement) >= -32'sd128 && $signed(displacement) <= 32'sd127)
                begin
                    put(bb, n, modrm(2'd1, a, 3'd5)); put(bb, n, displacement[7:0]);
                end
                else
                begin
                    put(bb, n, modrm(2'd2, a, 3'd5)); put32(bb, n, displacement);
                end
            end
            OP_LOAD_ABS:
            begin
                op_imm(bb, n, 3'd0, immediate);
                put(bb, n, 8'h48); put(bb, n, 8'h8B); put(bb, n, modrm(2'd0, 3'd0, 3'd0));
            end
            OP_STORE_ABS:
            begin
                rr(bb, n, 8'h89, 3'd0, 3'd1);
                op_imm(bb, n, 3'd0, immediate);
                put(bb, n, 8'h48); put(bb, n, 8'h89); put(bb, n, modrm(2'd0, 3'd1, 3'd0));
            end
            OP_JMP:
            begin
                put(bb, n, 8'hE9); put32(bb, n, 32'd0);
            end
            OP_CALL:
            begin
                put(bb, n, 8'hE8); put32(bb, n, 32'd0);
            end
            OP_RET:       put(bb, n, 8'hC3);
            OP_JCC:
            begin
                put(bb, n, 8'h0F); put(bb, n, 8'h80 + {4'd0, cond_code}); put32(bb, n, 32'd0);
            end
            OP_PATCH:
            begin
                n                 = CNT_W'(4);
                enc_next.patch    = 1'b1;
                enc_next.rel_mode = 1'b1;
                enc_next.rel_base = target + 32'd4;
            end
            OP_JMP_TO:
            begin
                put(bb, n, 8'hE9); put32(bb, n, 32'd0);
                enc_next.rel_mode = 1'b1;
                enc_next.rel_base = target - 32'd5;
            end
            OP_SETCC:
            begin
                put(bb, n, 8'h0F); put(bb, n, 8'h90 + {4'd0, cond_code}); put(bb, n, 8'hC0);
                put(bb, n, 8'h0F); put(bb, n, 8'hB6); put(bb, n, 8'hC0);
            end
            OP_PROLOGUE:
            begin
                put(bb, n, 8'h55);
                rr(bb, n, 8'h89, 3'd4, 3'd5);
                if (immediate[31:0] != 32'd0)
                begin
                    rr(bb, n, 8'h81, 3'd5, 3'd4); put32(bb, n, immediate[31:0]);
                end
            end
            OP_EPILOGUE:
            begin
                put(bb, n, 8'hC9); put(bb, n, 8'hC3);
            end
            OP_ADD_I8:
            begin
                rr(bb, n, 8'h83, 3'd0, a); put(bb, n, immediate[7:0]);
            end
            OP_SUB_I8:
            begin
                rr(bb, n, 8'h83, 3'd5, a); put(bb, n, immediate[7:0]);
            end
            OP_PUSH_R:    popx(bb, n, 8'h50, reg_a);
            OP_POP_R:     popx(bb, n, 8'h58, reg_a);
            OP_MOV_RR, OP_ADD_RR, OP_SUB_RR:
            begin
                put(bb, n, rex);
                put(bb, n, (operation == OP_MOV_RR) ? 8'h89 :
                           (operation == OP_ADD_RR) ? 8'h01 : 8'h29);
                put(bb, n, modrm(2'd3, reg_b[2:0], reg_a[2:0]));
            end
            OP_SYSCALL:
            begin
                put(bb, n, 8'h0F); put(bb, n, 8'h05);
            end
            OP_EMIT_SC:
            begin
                // argument pops run from the last register down: r9 r8 r10 rdx rsi rdi
                if (nargs >= 3'd6) popx(bb, n, 8'h58, 4'd9);
                if (nargs >= 3'd5) popx(bb, n, 8'h58, 4'd8);
                if (nargs >= 3'd4) popx(bb, n, 8'h58, 4'd10);
                if (nargs >= 3'd3) popx(bb, n, 8'h58, 4'd2);
                if (nargs >= 3'd2) popx(bb, n, 8'h58, 4'd6);
                if (nargs >= 3'd1) popx(bb, n, 8'h58, 4'd7);
                op_imm(bb, n, 3'd0, {48'd0, immediate[15:0]});
                put(bb, n, 8'h0F); put(bb, n, 8'h05);
            end
            default: ;
        endcase
        enc_next.bytes  = bb;
        enc_next.count  = n;
        enc_next.target = target;
    end

    // queue register toward the back part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enc_valid_reg <= 1'b0;
        else if (ready)
            enc_valid_reg <= acc && (n != '0);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            enc_reg <= enc_next;
    end

    assign enc_valid = enc_valid_reg;
    assign enc       = enc_reg;

endmodule

FILE: design/xenc_back.sv
module xenc_back
    import xenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enc_valid,
    output logic        enc_ready,
    input  enc_t        enc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic [31:0] byte_offset,
    output logic        last
);

    enc_t             cur_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [31:0]      wp_reg;
    logic [31:0]      rel_reg;
    logic             ov_reg;
    logic [7:0]       ob_reg;
    logic [31:0]      oo_reg;
    logic             ol_reg;
    logic             take;
    logic             emit;
    logic             fin;
    logic [31:0]      rel_now;
    logic [7:0]       byte_v;
    logic [1:0]       lane;

    // write position once the byte in flight this cycle is counted
    function automatic logic [31:0] wp_next_start();
        return (emit && !cur_reg.patch) ? wp_reg + 32'd1 : wp_reg;
    endfunction

    assign take      = enc_valid && enc_ready;
    assign enc_ready = !busy_reg || (emit && fin);
    assign emit      = busy_reg && (!ov_reg || out_ready);
    assign fin       = (idx_reg + 1'b1) == cur_reg.count;
    assign rel_now   = cur_reg.patch ? rel_reg : rel_reg;

    // pick the byte: relative field bytes are spliced in from rel_reg
    always_comb
    begin
        lane   = 2'(idx_reg - (cur_reg.patch ? CNT_W'(0) : CNT_W'(1)));
        byte_v = cur_reg.bytes[idx_reg];
        if (cur_reg.rel_mode && (cur_reg.patch || idx_reg != '0))
            byte_v = rel_now[8*lane +: 8];
    end

    // byte sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            wp_reg   <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (out_ready)
                ov_reg <= 1'b0;
            if (emit)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
                if (!cur_reg.patch)
                    wp_reg <= wp_reg + 32'd1;
                if (fin)
                    busy_reg <= 1'b0;
            end
            if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= enc;
            // wp at this point is the request's start position
            rel_reg <= enc.patch ? (wp_next_start() - enc.rel_base)
                                 : (enc.rel_base - wp_next_start());
        end
        if (emit)
        begin
            ob_reg <= byte_v;
            oo_reg <= cur_reg.patch ? cur_reg.target + 32'(idx_reg) : wp_reg;
            ol_reg <= fin;
        end
    end

    assign out_valid   = ov_reg;
    assign code_byte   = ob_reg;
    assign byte_offset = oo_reg;
    assign last        = ol_reg;

endmodule

FILE: design/x86_64_instruction_encoder.sv
// channel | handshake       | fields
// in      | valid / ready   | operation reg_a reg_b immediate displacement cond_code target arg_count
// out     | out_valid/out_ready | code_byte byte_offset last
// one byte leaves per cycle while out is not stalled; a request emits 1 to 16 bytes,
// an unknown operation is accepted and emits nothing
// the front encodes a request combinationally into a one-entry queue register while the back emits
// the previous one; the back's byte sequencer sets the rate
// reset clears the write position to zero; a stall on out holds the byte in place
module x86_64_instruction_encoder
    import xenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [5:0]  operation,
    input  logic [3:0]  reg_a,
    input  logic [3:0]  reg_b,
    input  logic [63:0] immediate,
    input  logic [31:0] displacement,
    input  logic [3:0]  cond_code,
    input  logic [31:0] target,
    input  logic [2:0]  arg_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic [31:0] byte_offset,
    output logic        last
);

    logic enc_valid;
    logic enc_ready;
    enc_t enc;

    xenc_front u_front (
        .clk, .rst_n, .valid, .ready, .operation, .reg_a, .reg_b, .immediate,
        .displacement, .cond_code, .target, .arg_count,
        .enc_valid, .enc_ready, .enc
    );

    xenc_back u_back (
        .clk, .rst_n, .enc_valid, .enc_ready, .enc,
        .out_valid, .out_ready, .code_byte, .byte_offset, .last
    );

endmodule
